// File: hw/rtl/assert_macros.svh
// assertion macros shared by the battery monitor converter rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BMUC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define BMUC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: hw/rtl/bmuc_pkg.sv
// shared types and constants for the battery monitor unit converter
// no dependencies; imported by every module of the block
package bmuc_pkg;

    // reading kinds
    localparam logic [1:0] CMD_CELL   = 2'd0;
    localparam logic [1:0] CMD_THERM  = 2'd1;
    localparam logic [1:0] CMD_CURR   = 2'd2;
    localparam logic [1:0] CMD_CHARGE = 2'd3;

    localparam int MAX_CELLS  = 7;
    localparam int CNT_W      = 5;
    localparam logic [2:0] PACK_CELLS_RST = 3'd4;

    localparam logic [11:0] TS_REF  = 12'd2545;
    localparam logic [24:0] TS_PULL = 25'd10000;

    // x / 1440 is (x >> 5) / 45, done as a reciprocal multiply on 27 bits
    localparam logic [28:0] CC_RECIP       = 29'd381774871;
    localparam int          CC_RECIP_SHIFT = 34;

    // divider geometry
    localparam int DIV_W   = 32;
    localparam int DEN_W   = 12;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic commit;
    } bmuc_ctrl_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } bmuc_sts_t;

endpackage

// File: hw/rtl/bmuc_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on bmuc_pkg for the dividend, divisor and counter widths
module bmuc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bmuc_pkg::DIV_W-1:0]    dividend,
    input  logic [bmuc_pkg::DEN_W-1:0]    divisor,
    output logic                          done,
    output logic [bmuc_pkg::DIV_W-1:0]    quotient
);
    import bmuc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DEN_W:0]      trial;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the trial fits one extra bit
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/bmuc_dp.sv
// datapath: request capture, unit conversion, cell/pack/resistance state, result register
// depends on bmuc_pkg and bmuc_div; driven by bmuc_ctrl through bmuc_ctrl_t
`include "assert_macros.svh"
module bmuc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_wr_data,
    input  logic [1:0]                        in_cmd,
    input  logic [bmuc_pkg::S_TDATA_W-1:0]    in_raw,
    input  bmuc_pkg::bmuc_ctrl_t              ctrl,
    output bmuc_pkg::bmuc_sts_t               sts,
    output logic [bmuc_pkg::M_TDATA_W-1:0]    out_tdata,
    output logic [bmuc_pkg::M_TUSER_W-1:0]    out_tuser,
    output logic                              out_tlast
);
    import bmuc_pkg::*;

    logic [1:0]          cmd_reg;
    logic [31:0]         raw_reg;
    logic [2:0]          pack_cells_reg;
    logic [2:0]          cell_pos_reg, cell_pos_next;
    logic [15:0]         pack_sum_reg, pack_sum_next;
    logic [24:0]         held_res_reg, held_res_next;

    logic [25:0]         conv_reg, conv_next;
    logic [2:0]          idx_reg, idx_next;
    logic [15:0]         pack_out_reg, pack_out_next;
    logic                done_reg, done_next;
    logic                upd_reg, upd_next;
    logic [1:0]          kind_reg;

    logic [15:0]         raw16;
    logic [18:0]         cell_prod;
    logic [12:0]         mv;
    logic [17:0]         ts_prod;
    logic [11:0]         ts_mv;
    logic                therm_ok;
    logic [24:0]         therm_num;
    logic [11:0]         therm_den;
    logic [DIV_W-1:0]    div_dividend;
    logic [DEN_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    quotient;

    logic [55:0]         cc_prod;
    logic [21:0]         cc_mah;

    logic [CNT_W-1:0]    eff_count;
    logic                pack_last;
    logic [15:0]         pack_new;

    logic signed [18:0]  cur_s;
    logic signed [18:0]  cur_p;
    logic signed [18:0]  cur_adj;
    logic signed [17:0]  cur_ma;

    assign raw16 = raw_reg[15:0];

    // x * 78125 / 1000000 is x * 5 / 64
    assign cell_prod = {1'b0, raw16, 2'b00} + {3'b000, raw16};
    assign mv        = cell_prod[18:6];
    assign ts_prod   = {1'b0, raw16[14:0], 2'b00} + {3'b000, raw16[14:0]};
    assign ts_mv     = ts_prod[17:6];

    assign therm_ok  = raw16[15] && (ts_mv != '0) && (ts_mv < TS_REF);
    assign therm_num = 25'(ts_mv) * TS_PULL;
    assign therm_den = TS_REF - ts_mv;

    assign div_dividend = DIV_W'(therm_num);
    assign div_divisor  = therm_den;

    // exact for every 27-bit quotient of raw / 32
    assign cc_prod = 56'(raw_reg[31:5]) * 56'(CC_RECIP);
    assign cc_mah  = cc_prod[55:CC_RECIP_SHIFT];

    assign sts.need_div = (cmd_reg == CMD_THERM) && therm_ok;
    assign sts.div_done = div_done;

    bmuc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // zero count means one cell, counts above the limit saturate
    always_comb begin
        if (pack_cells_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (CNT_W'(pack_cells_reg) > CNT_W'(MAX_CELLS)) begin
            eff_count = CNT_W'(MAX_CELLS);
        end else begin
            eff_count = CNT_W'(pack_cells_reg);
        end
    end

    assign pack_last = (CNT_W'(cell_pos_reg) + CNT_W'(1)) >= eff_count;
    assign pack_new  = pack_sum_reg + 16'(mv);

    // signed x * 5 / 2, rounded toward zero
    assign cur_s   = 19'(signed'(raw16));
    assign cur_p   = (cur_s <<< 2) + cur_s;
    assign cur_adj = cur_p + 19'(cur_p[18]);
    assign cur_ma  = cur_adj[18:1];

    always_comb begin
        conv_next     = '0;
        idx_next      = '0;
        pack_out_next = '0;
        done_next     = 1'b0;
        upd_next      = 1'b0;
        cell_pos_next = cell_pos_reg;
        pack_sum_next = pack_sum_reg;
        held_res_next = held_res_reg;
        case (cmd_reg)
            CMD_CELL: begin
                conv_next     = 26'(mv);
                idx_next      = cell_pos_reg;
                pack_out_next = pack_new;
                if (pack_last) begin
                    done_next     = 1'b1;
                    cell_pos_next = '0;
                    pack_sum_next = '0;
                end else begin
                    cell_pos_next = cell_pos_reg + 1'b1;
                    pack_sum_next = pack_new;
                end
            end
            CMD_THERM: begin
                if (therm_ok) begin
                    held_res_next = quotient[24:0];
                    conv_next     = 26'(quotient[24:0]);
                    upd_next      = 1'b1;
                end else begin
                    conv_next     = 26'(held_res_reg);
                end
            end
            CMD_CURR: begin
                conv_next = {{8{cur_ma[17]}}, cur_ma};
            end
            CMD_CHARGE: begin
                conv_next = 26'(cc_mah);
            end
            default: begin
                conv_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_cells_reg <= PACK_CELLS_RST;
            cell_pos_reg   <= '0;
            pack_sum_reg   <= '0;
            held_res_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                pack_cells_reg <= cfg_wr_data;
            end
            if (ctrl.commit) begin
                cell_pos_reg <= cell_pos_next;
                pack_sum_reg <= pack_sum_next;
                held_res_reg <= held_res_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            cmd_reg <= in_cmd;
            raw_reg <= in_raw;
        end
        if (ctrl.commit) begin
            kind_reg     <= cmd_reg;
            conv_reg     <= conv_next;
            idx_reg      <= idx_next;
            pack_out_reg <= pack_out_next;
            done_reg     <= done_next;
            upd_reg      <= upd_next;
        end
    end

    assign out_tdata = {3'b000, pack_out_reg, idx_reg, conv_reg};
    assign out_tuser = {upd_reg, kind_reg};
    assign out_tlast = done_reg;

    `BMUC_ASSERT(a_pos_in_range, aclk, aresetn,
        CNT_W'(cell_pos_reg) < CNT_W'(MAX_CELLS), "cell position beyond cell limit")

endmodule

// File: hw/rtl/bmuc_ctrl.sv
// controller: request sequencing, divider launch and result handoff
// depends on bmuc_pkg; commands bmuc_dp through bmuc_ctrl_t
`include "assert_macros.svh"
module bmuc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  bmuc_pkg::bmuc_sts_t   sts,
    output bmuc_pkg::bmuc_ctrl_t  ctrl
);
    import bmuc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_axis_tready  = (state_reg == ST_IDLE);
    assign ctrl.load_in   = s_axis_tvalid && s_axis_tready;
    assign ctrl.div_start = (state_reg == ST_CALC) && sts.need_div;
    assign ctrl.commit    = (state_reg == ST_FIN) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (ctrl.load_in) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = sts.need_div ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (ctrl.commit) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;

    `BMUC_ASSERT(a_div_done_in_div, aclk, aresetn,
        sts.div_done |-> (state_reg == ST_DIV), "divider finished outside divide state")
    `BMUC_ASSERT(a_commit_shows, aclk, aresetn,
        ctrl.commit |=> m_axis_tvalid, "committed result not presented")
    `BMUC_ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> (state_reg == ST_IDLE) && !m_valid_reg, "reset did not clear control")

endmodule

// File: hw/rtl/battery_monitor_unit_converter.sv
// channel    dir   tdata                         tuser                        tlast
// s_axis     in    raw_value[31:0]               cmd[1:0]                     -
// m_axis     out   converted_value, cell_index,  kind[1:0],                   pack_done
//                  pack_millivolts (48b padded)  resistance_updated
//
// one request at a time: every reading passes through the idle, calc and fin states;
// a thermistor reading that makes a new resistance also waits in the div state for
// the 32-step radix-2 divider
// a finished result sits in the output register, so the next request is taken
// while it waits; a stalled m_axis holds the block only once a second result is ready
// aresetn is synchronous, active low: cell count back to 4, pack and resistance cleared
//
// top level of the battery monitor unit converter
// depends on bmuc_pkg, bmuc_ctrl, bmuc_dp and bmuc_div
module battery_monitor_unit_converter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_wr_data,   // pack_cells
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bmuc_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // raw_value[31:0]
    input  logic [1:0]                        s_axis_tuser,  // cmd[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // converted_value[25:0], cell_index[28:26], pack_millivolts[44:29], zero[47:45]
    output logic [bmuc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic [bmuc_pkg::M_TUSER_W-1:0]    m_axis_tuser,  // kind[1:0], resistance_updated[2]
    output logic                              m_axis_tlast   // pack_done
);
    import bmuc_pkg::*;

    bmuc_ctrl_t ctrl;
    bmuc_sts_t  sts;

    bmuc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .ctrl          (ctrl)
    );

    bmuc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (s_axis_tuser),
        .in_raw      (s_axis_tdata),
        .ctrl        (ctrl),
        .sts         (sts),
        .out_tdata   (m_axis_tdata),
        .out_tuser   (m_axis_tuser),
        .out_tlast   (m_axis_tlast)
    );

endmodule
